/* hw/rtl/lfsd_pkg.sv */
// Shared types and constants for the line-follow steering and drive controller.
// Used by every module of the block; depends on nothing else.
package lfsd_pkg;

    // Shared multiplier operand and product widths.
    localparam int MUL_W  = 18;
    localparam int PROD_W = 36;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LIN    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_QUAD   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_MAX    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_LO    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEER_HI    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_GAIN  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FLOOR = 4'd7;

    // Marker event codes.
    localparam logic [1:0] EVT_NONE     = 2'd0;
    localparam logic [1:0] EVT_PICKUP   = 2'd1;
    localparam logic [1:0] EVT_DELIVERY = 2'd2;

    // Fixed operating points.
    localparam logic [15:0] STEER_CENTER  = 16'd32768;
    localparam logic [15:0] STEER_LOST    = 16'd13107;
    localparam logic [15:0] DRIVE_LOST_MV = 16'hE890;   // -6000 mV
    localparam int          CENTER_MAX    = 1024;
    localparam int          STRAIGHT_MAX  = 819;
    localparam int          SCALE_ONE     = 4096;
    localparam int          SCALE_CAP     = 6144;
    localparam int          DRIVE_FULL_MV = 12000;
    localparam logic [7:0]  MASK_CENTER   = 8'h3C;      // active mask 0x7E folded in
    localparam logic [7:0]  STREAK_MAX    = 8'd255;

    // Configuration register file contents.
    typedef struct packed {
        logic        [15:0] ema_alpha;
        logic signed [15:0] gain_linear;
        logic signed [15:0] gain_quadratic;
        logic        [15:0] slew_step_max;
        logic        [15:0] steer_lower_limit;
        logic        [15:0] steer_upper_limit;
        logic        [15:0] brake_gain;
        logic        [12:0] drive_scale_floor;
    } t_cfg;

    // Frame summary handed to the marker detector.
    typedef struct packed {
        logic               upd;
        logic               clr;
        logic        [7:0]  bits;
        logic        [3:0]  lit;
        logic signed [13:0] pos;
        logic signed [15:0] err;
    } t_mark_req;

endpackage

/* hw/rtl/lfsd_cfg.sv */
// Configuration register file of the line-follow controller.
// Depends on lfsd_pkg for the register indexes and the t_cfg struct.
module lfsd_cfg
    import lfsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ema_alpha         <= 16'd32768;
            r_cfg.gain_linear       <= -16'sd246;
            r_cfg.gain_quadratic    <= -16'sd6963;
            r_cfg.slew_step_max     <= 16'd13107;
            r_cfg.steer_lower_limit <= 16'd9830;
            r_cfg.steer_upper_limit <= 16'd55705;
            r_cfg.brake_gain        <= 16'd18432;
            r_cfg.drive_scale_floor <= 13'd1229;
        end else if (i_wr) begin
            unique case (i_index)
                REG_EMA_ALPHA:   r_cfg.ema_alpha         <= i_data;
                REG_GAIN_LIN:    r_cfg.gain_linear       <= $signed(i_data);
                REG_GAIN_QUAD:   r_cfg.gain_quadratic    <= $signed(i_data);
                REG_SLEW_MAX:    r_cfg.slew_step_max     <= i_data;
                REG_STEER_LO:    r_cfg.steer_lower_limit <= i_data;
                REG_STEER_HI:    r_cfg.steer_upper_limit <= i_data;
                REG_BRAKE_GAIN:  r_cfg.brake_gain        <= i_data;
                REG_SCALE_FLOOR: r_cfg.drive_scale_floor <= i_data[12:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/lfsd_mul.sv */
// Shared signed multiplier with a registered product.
// Depends on lfsd_pkg for the operand and product widths.
module lfsd_mul
    import lfsd_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // One product per cycle, available in the following cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

/* hw/rtl/lfsd_marker.sv */
// Pickup and delivery marker detector with saturating streak counters.
// Depends on lfsd_pkg for the event codes and the t_mark_req struct.
module lfsd_marker
    import lfsd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_mark_req i_req,
    output logic [1:0] o_event
);

    logic [7:0] r_pick;
    logic [7:0] r_deliv;
    logic [7:0] n_pick;
    logic [7:0] n_deliv;
    logic [3:0] w_cbits;
    logic [7:0] w_cmask;
    logic       w_centered;
    logic       w_straight;
    logic       w_pick;
    logic       w_deliv;

    // Count the lit central elements.
    assign w_cmask = i_req.bits & MASK_CENTER;
    always_comb begin
        w_cbits = 4'd0;
        for (int i = 0; i < 8; i++) begin
            w_cbits = w_cbits + {3'b0, w_cmask[i]};
        end
    end

    // Candidate tests on the measured angle and the filtered error.
    assign w_centered = (i_req.pos >= -14'sd1024) && (i_req.pos <= 14'sd1024);
    assign w_straight = (i_req.err >= -16'sd819) && (i_req.err <= 16'sd819);
    assign w_pick     = w_centered && w_straight && (i_req.lit >= 4'd5);
    assign w_deliv    = w_centered && w_straight && (i_req.lit >= 4'd3) &&
                        (i_req.lit <= 4'd4) && (w_cbits >= 4'd2);

    // Streaks count up on a candidate and clear otherwise.
    assign n_pick  = w_pick  ? ((r_pick  < STREAK_MAX) ? r_pick  + 8'd1 : STREAK_MAX) : 8'd0;
    assign n_deliv = w_deliv ? ((r_deliv < STREAK_MAX) ? r_deliv + 8'd1 : STREAK_MAX) : 8'd0;

    // The event is reported from the updated streaks, before a lost-line clear.
    always_comb begin
        if (n_pick >= 8'd1) begin
            o_event = EVT_PICKUP;
        end else if (n_deliv >= 8'd2) begin
            o_event = EVT_DELIVERY;
        end else begin
            o_event = EVT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pick  <= 8'd0;
            r_deliv <= 8'd0;
        end else if (i_req.upd) begin
            r_pick  <= i_req.clr ? 8'd0 : n_pick;
            r_deliv <= i_req.clr ? 8'd0 : n_deliv;
        end
    end

endmodule

/* hw/rtl/line_follow_steer_drive_controller.sv */
// Line-follow steering and drive controller, top level.
// An accepted frame steps through S_EMA to S_DONE, with seven passes through the
// single shared 18x18 multiplier under the sequencer, before its result is loaded.
// A new frame is taken only in S_IDLE, also while a result still waits. Synchronous
// active-low reset restores the state, filtered error, steering and output valid flag.
// Depends on lfsd_pkg, lfsd_cfg, lfsd_mul and lfsd_marker.
module line_follow_steer_drive_controller
    import lfsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input frame stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // sensor_bits[7:0], lit_count[11:8],
                                                 // line_angle[25:12], zero fill
    input  logic                  s_axis_tuser,  // line_present
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [39:0]           m_axis_tdata,  // marker_event[1:0], steer_command[17:2],
                                                 // drive_millivolts[33:18], zero fill
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_EMA, S_FILT, S_SQ, S_LIN, S_QUAD, S_ERR2, S_BRAKE, S_CLAMP, S_DRV, S_DONE
    } t_state;

    t_state r_state;
    t_cfg   w_cfg;

    // Frame and working registers.
    logic        [7:0]  r_bits;
    logic        [3:0]  r_lit;
    logic               r_present;
    logic signed [13:0] r_pos;
    logic signed [15:0] r_fe;
    logic        [15:0] r_steer;
    logic signed [15:0] r_sq;
    logic signed [32:0] r_acc;
    logic signed [19:0] r_scale;
    logic        [15:0] r_steer_nx;
    logic               r_m_valid;
    logic        [1:0]  r_m_event;
    logic        [15:0] r_m_steer;
    logic        [15:0] r_m_drive;

    // Multiplier operands and product.
    logic signed [MUL_W-1:0]  w_a;
    logic signed [MUL_W-1:0]  w_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_rnd16;
    logic signed [PROD_W-1:0] w_rnd12;
    logic signed [PROD_W-1:0] w_rnd10;

    logic signed [16:0] w_diff_ema;
    logic        [14:0] w_err_abs;
    logic        [14:0] w_pos_abs;
    logic        [14:0] w_grow;
    logic signed [15:0] n_fe;
    logic signed [19:0] w_scale_b;
    logic signed [19:0] n_scale;
    logic signed [25:0] w_outp;
    logic signed [27:0] w_target;
    logic signed [27:0] w_diff;
    logic signed [27:0] w_slew;
    logic signed [27:0] w_delta;
    logic signed [27:0] w_sp;
    logic signed [27:0] w_lo;
    logic signed [27:0] w_hi;
    logic        [15:0] n_steer;
    logic        [15:0] w_drive;
    logic        [1:0]  w_event;
    logic               w_in_acc;
    logic               w_out_free;
    t_mark_req          w_mreq;

    lfsd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    lfsd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    // Neither input channel takes a beat while reset is held.
    assign o_cfg_ready   = i_rst_n;
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // Magnitudes of the measured angle and the filtered error.
    assign w_err_abs = r_fe[15] ? 15'(-r_fe) : r_fe[14:0];
    assign w_pos_abs = r_pos[13] ? 15'(-$signed({r_pos[13], r_pos})) : {1'b0, r_pos};
    assign w_grow    = (w_pos_abs > w_err_abs) ? (w_pos_abs - w_err_abs) : 15'd0;
    assign w_diff_ema = $signed({{3{r_pos[13]}}, r_pos}) - $signed({r_fe[15], r_fe});

    // Round-to-nearest shifts of the product, ties toward plus infinity.
    assign w_rnd16 = (w_prod + 36'sd32768) >>> 16;
    assign w_rnd12 = (w_prod + 36'sd2048) >>> 12;
    assign w_rnd10 = (w_prod + 36'sd512) >>> 10;

    // Multiplier operand selection per sequencer step.
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            S_EMA: begin
                w_a = $signed({2'b0, w_cfg.ema_alpha});
                w_b = MUL_W'(w_diff_ema);
            end
            S_SQ: begin
                w_a = MUL_W'(r_fe);
                w_b = $signed({3'b0, w_err_abs});
            end
            S_LIN: begin
                w_a = MUL_W'(w_cfg.gain_linear);
                w_b = MUL_W'(r_fe);
            end
            S_QUAD: begin
                w_a = MUL_W'(w_cfg.gain_quadratic);
                w_b = MUL_W'(r_sq);
            end
            S_ERR2: begin
                w_a = MUL_W'(r_fe);
                w_b = MUL_W'(r_fe);
            end
            S_BRAKE: begin
                w_a = $signed({3'b0, w_grow});
                w_b = $signed({2'b0, w_cfg.brake_gain});
            end
            S_DRV: begin
                w_a = 18'sd12000;
                w_b = MUL_W'(r_scale);
            end
            // The drive product is kept while the result waits for the receiver.
            S_DONE: begin
                w_a = 18'sd12000;
                w_b = MUL_W'(r_scale);
            end
            default: ;
        endcase
    end

    // EMA update of the filtered error.
    assign n_fe = r_fe + 16'(w_rnd16);

    // Braking penalty, then floor and cap of the drive scale.
    assign w_scale_b = r_scale - 20'(w_rnd12);
    always_comb begin
        n_scale = w_scale_b;
        if (w_scale_b < $signed({7'b0, w_cfg.drive_scale_floor})) begin
            n_scale = $signed({7'b0, w_cfg.drive_scale_floor});
        end
        if (n_scale > 20'sd6144) begin
            n_scale = 20'sd6144;
        end
    end

    // Steering target, slew limit and clamp to the steering range.
    assign w_outp   = 26'((r_acc + 33'sd128) >>> 8);
    assign w_target = $signed({12'b0, STEER_CENTER}) - 28'(w_outp);
    assign w_diff   = w_target - $signed({12'b0, r_steer});
    assign w_slew   = $signed({12'b0, w_cfg.slew_step_max});
    assign w_lo     = $signed({12'b0, w_cfg.steer_lower_limit});
    assign w_hi     = $signed({12'b0, w_cfg.steer_upper_limit});
    assign w_delta  = (w_diff < -w_slew) ? -w_slew : ((w_diff > w_slew) ? w_slew : w_diff);
    assign w_sp     = $signed({12'b0, r_steer}) + w_delta;
    assign n_steer  = (w_sp < w_lo) ? w_lo[15:0] : ((w_sp > w_hi) ? w_hi[15:0] : w_sp[15:0]);

    // Drive voltage from the clamped scale.
    assign w_drive = -w_rnd12[15:0];

    // Marker detector sees the frame once the filtered error is final.
    assign w_mreq.upd  = (r_state == S_DONE) && w_out_free;
    assign w_mreq.clr  = !r_present;
    assign w_mreq.bits = r_bits;
    assign w_mreq.lit  = r_lit;
    assign w_mreq.pos  = r_pos;
    assign w_mreq.err  = r_fe;

    lfsd_marker u_marker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_event (w_event)
    );

    // Sequencer, working registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fe      <= '0;
            r_steer   <= STEER_CENTER;
            r_m_valid <= 1'b0;
        end else begin
            // The output register fills on the final step and empties on a result beat.
            if ((r_state == S_DONE) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_bits    <= s_axis_tdata[7:0];
                        r_lit     <= s_axis_tdata[11:8];
                        r_present <= s_axis_tuser;
                        r_pos     <= s_axis_tuser ? $signed(s_axis_tdata[25:12]) : 14'sd0;
                        r_state   <= S_EMA;
                    end
                end
                S_EMA: r_state <= S_FILT;
                S_FILT: begin
                    r_fe    <= n_fe;
                    r_state <= S_SQ;
                end
                S_SQ: r_state <= S_LIN;
                S_LIN: begin
                    r_sq    <= 16'(w_rnd12);
                    r_state <= S_QUAD;
                end
                S_QUAD: begin
                    r_acc   <= 33'(w_prod);
                    r_state <= S_ERR2;
                end
                S_ERR2: begin
                    r_acc   <= r_acc + 33'(w_prod);
                    r_state <= S_BRAKE;
                end
                S_BRAKE: begin
                    r_scale <= 20'sd4096 - 20'(w_rnd10);
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    r_scale <= n_scale;
                    r_state <= S_DRV;
                end
                S_DRV: begin
                    r_steer_nx <= n_steer;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_event <= w_event;
                        if (r_present) begin
                            r_steer   <= r_steer_nx;
                            r_m_steer <= r_steer_nx;
                            r_m_drive <= w_drive;
                        end else begin
                            r_fe      <= '0;
                            r_steer   <= STEER_LOST;
                            r_m_steer <= STEER_LOST;
                            r_m_drive <= DRIVE_LOST_MV;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'b0, r_m_drive, r_m_steer, r_m_event};

    // The filtered error never leaves the angle range.
    a_fe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fe >= -16'sd8192) && (r_fe <= 16'sd8191))
        else $error("filtered error out of range");

    // The drive scale is clamped before it reaches the multiplier.
    a_scale_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRV) |-> ((r_scale >= 20'sd0) && (r_scale <= 20'sd6144)))
        else $error("drive scale not clamped");

    // A driven result is always a forward drive of at most 18 V.
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (($signed(m_axis_tdata[33:18]) <= 16'sd0) &&
                           ($signed(m_axis_tdata[33:18]) >= -16'sd18000)))
        else $error("drive voltage out of range");

    // A result is loaded only on the way back to idle.
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_m_valid)) |-> (r_state == S_IDLE))
        else $error("result loaded outside the final step");

endmodule

/* dv/tb_line_follow_steer_drive_controller.sv */
// Self-checking testbench for the line-follow steering and drive controller.
// A cycle-free predictor in longint arithmetic scores all but typed rows' result beats;
// depends on lfsd_pkg and the line_follow_steer_drive_controller top level.
module tb_line_follow_steer_drive_controller;
    import lfsd_pkg::*;

    // Unused register window on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 4'd15;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 12;
    localparam int N_DIRECTED   = 22;

    typedef struct packed {
        logic [7:0]         bits;
        logic [3:0]         lit;
        logic               present;
        logic signed [13:0] angle;
    } t_frame;

    typedef struct packed {
        logic [1:0]         marker;
        logic [15:0]        steer;
        logic signed [15:0] drive;
    } t_steer_drive;

    typedef struct packed {
        t_frame       f;
        logic         typed;
        t_steer_drive r;
    } t_stim_row;

    typedef enum int {KIND_PICKUP, KIND_DELIVERY, KIND_CURVE, KIND_NOISE} t_frame_kind;

    localparam t_steer_drive NOT_TYPED = '0;
    localparam t_steer_drive LOST_NONE = '{EVT_NONE, STEER_LOST, DRIVE_LOST_MV};
    localparam t_steer_drive LOST_PICK = '{EVT_PICKUP, STEER_LOST, DRIVE_LOST_MV};

    // Directed frames; rows with a typed result skip the predictor's answer.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{'{8'h00, 4'd0,  1'b0, 14'h0000}, 1'b1, LOST_NONE},  // lost line right after reset
        '{'{8'hFF, 4'd8,  1'b0, 14'h0000}, 1'b1, LOST_PICK},  // lost line, all elements lit
        '{'{8'h3C, 4'd15, 1'b0, 14'h1FFF}, 1'b1, LOST_PICK},  // count above eight
        '{'{8'h00, 4'd0,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},
        '{'{8'h5A, 4'd2,  1'b1, 14'h1FFF}, 1'b0, NOT_TYPED},  // largest angle
        '{'{8'hA5, 4'd1,  1'b1, 14'h2000}, 1'b0, NOT_TYPED},  // most negative angle
        '{'{8'hFF, 4'd5,  1'b1, 14'h0400}, 1'b0, NOT_TYPED},  // centered edge
        '{'{8'hFF, 4'd5,  1'b1, 14'h0401}, 1'b0, NOT_TYPED},  // just off center
        '{'{8'h3C, 4'd3,  1'b1, 14'h3C00}, 1'b0, NOT_TYPED},
        '{'{8'h18, 4'd4,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},  // delivery streak
        '{'{8'h18, 4'd4,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},
        '{'{8'h18, 4'd4,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},
        '{'{8'h18, 4'd4,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},
        '{'{8'h04, 4'd4,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},  // one central bit only
        '{'{8'h81, 4'd3,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},  // no central bits
        '{'{8'h7E, 4'd6,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},  // pickup streak
        '{'{8'h7E, 4'd6,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},
        '{'{8'h7E, 4'd6,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},
        '{'{8'h42, 4'd9,  1'b1, 14'h0000}, 1'b0, NOT_TYPED},
        '{'{8'hC3, 4'd15, 1'b1, 14'h3FFF}, 1'b0, NOT_TYPED},
        '{'{8'h00, 4'd0,  1'b0, 14'h1234}, 1'b0, NOT_TYPED},  // line lost mid-run
        '{'{8'hFF, 4'd7,  1'b1, 14'h0000}, 1'b0, NOT_TYPED}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata  = '0;  // sensor_bits, lit_count, line_angle, zero fill
    logic                  s_axis_tuser  = 1'b0;  // line_present
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [39:0]           m_axis_tdata;  // marker_event, steer_command, drive_millivolts, fill
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Typed expectation riding along with the frame on the bus.
    logic         row_typed  = 1'b0;
    t_steer_drive row_result = '0;

    // Predictor state and shadow configuration, at their reset values.
    t_cfg        cfg_shadow = '{16'd32768, -16'sd246, -16'sd6963, 16'd13107,
                                16'd9830, 16'd55705, 16'd18432, 13'd1229};
    longint      nav_err      = 0;
    longint      servo_pos    = 32768;
    int unsigned pickup_run   = 0;
    int unsigned delivery_run = 0;

    t_steer_drive expected_results [$];
    int           mismatches  = 0;
    int           burst_left  = 0;
    int           quiet_count = 0;

    line_follow_steer_drive_controller i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock with a 12-unit period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Arithmetic right shift rounding to nearest, ties toward plus infinity.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Plain clamp: when the bounds cross, values below the lower bound give it, all others the upper.
    function automatic longint bound(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advances the controller state by one frame and returns its result beat.
    function automatic t_steer_drive predict_steer_drive(input t_frame f);
        longint pos, err, sq, outp, target, delta, scale, n, slew, mag_pos, mag_err;
        longint gain_lin, gain_quad;
        bit centered, straight, pick, deliv;
        t_steer_drive r;
        pos       = f.present ? longint'($signed(f.angle)) : 64'sd0;
        gain_lin  = longint'($signed(cfg_shadow.gain_linear));
        gain_quad = longint'($signed(cfg_shadow.gain_quadratic));
        slew      = longint'(cfg_shadow.slew_step_max);

        // Exponential average of the measured angle.
        nav_err = nav_err + round_shift(longint'(cfg_shadow.ema_alpha) * (pos - nav_err), 16);
        err     = nav_err;

        // Marker streaks.
        centered = mag(pos) <= CENTER_MAX;
        straight = mag(err) <= STRAIGHT_MAX;
        pick     = centered && straight && (f.lit >= 5);
        deliv    = centered && straight && (f.lit >= 3) && (f.lit <= 4)
                   && ($countones(f.bits & MASK_CENTER) >= 2);
        pickup_run   = pick ? ((pickup_run < STREAK_MAX) ? pickup_run + 1 : STREAK_MAX) : 0;
        delivery_run = deliv ? ((delivery_run < STREAK_MAX) ? delivery_run + 1 : STREAK_MAX) : 0;
        r.marker = (pickup_run >= 1) ? EVT_PICKUP : ((delivery_run >= 2) ? EVT_DELIVERY : EVT_NONE);

        // Steering target, slew limit and clamp.
        sq        = round_shift(err * mag(err), 12);
        outp      = round_shift(gain_lin * err + gain_quad * sq, 8);
        target    = longint'(STEER_CENTER) - outp;
        delta     = bound(target - servo_pos, -slew, slew);
        servo_pos = bound(servo_pos + delta, longint'(cfg_shadow.steer_lower_limit),
                          longint'(cfg_shadow.steer_upper_limit));
        r.steer   = servo_pos[15:0];

        // Drive scale with braking while the error grows.
        n       = 2 * err;
        scale   = SCALE_ONE - round_shift(n * n, 12);
        mag_pos = mag(pos);
        mag_err = mag(err);
        if (mag_pos > mag_err) begin
            scale = scale - round_shift((mag_pos - mag_err) * longint'(cfg_shadow.brake_gain), 12);
        end
        if (scale < longint'(cfg_shadow.drive_scale_floor)) begin
            scale = longint'(cfg_shadow.drive_scale_floor);
        end
        if (scale > SCALE_CAP) begin
            scale = SCALE_CAP;
        end
        r.drive = 16'(-round_shift(DRIVE_FULL_MV * scale, 12));

        // Lost line: the event stands, everything else falls back.
        if (!f.present) begin
            nav_err      = 0;
            servo_pos    = STEER_LOST;
            pickup_run   = 0;
            delivery_run = 0;
            r.steer      = STEER_LOST;
            r.drive      = DRIVE_LOST_MV;
        end
        return r;
    endfunction

    // Random frame of a given flavor; the marker flavors keep the angle near center.
    function automatic t_frame random_frame(input t_frame_kind kind);
        t_frame f;
        int     i, j;
        f.bits    = 8'($urandom_range(0, 255));
        f.lit     = 4'($urandom_range(0, 15));
        f.present = 1'b1;
        f.angle   = 14'($urandom);
        case (kind)
            KIND_PICKUP: begin
                f.lit   = 4'($urandom_range(5, 15));
                f.angle = 14'($urandom_range(0, 2048) - 1024);
            end
            KIND_DELIVERY: begin
                i = $urandom_range(2, 5);
                j = $urandom_range(2, 5);
                if (j == i) begin
                    j = (i == 5) ? 2 : i + 1;
                end
                f.lit   = 4'($urandom_range(3, 4));
                f.bits  = f.bits | (8'd1 << i) | (8'd1 << j);
                f.angle = 14'($urandom_range(0, 2048) - 1024);
            end
            KIND_NOISE: begin
                f.present = 1'($urandom_range(0, 1));
            end
            default: ;
        endcase
        return f;
    endfunction

    // Sends one frame beat; the sender idles in random gaps between bursts.
    task automatic send_frame(input t_frame f, input logic typed, input t_steer_drive r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 24);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, f.angle, f.lit, f.bits};
        s_axis_tuser  <= f.present;
        row_typed     <= typed;
        row_result    <= r;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Runs of same-flavor frames, mostly marker sequences, some curves and noise.
    task automatic send_random(input int count);
        int          sent, run_len, roll;
        t_frame_kind kind;
        sent = 0;
        while (sent < count) begin
            roll    = $urandom_range(0, 99);
            kind    = (roll < 35) ? KIND_PICKUP : (roll < 70) ? KIND_DELIVERY :
                      (roll < 88) ? KIND_CURVE : KIND_NOISE;
            run_len = $urandom_range(1, 8);
            repeat (run_len) begin
                send_frame(random_frame(kind), 1'b0, NOT_TYPED);
                sent++;
            end
        end
    endtask

    // Holds the sender until every outstanding result beat has come back.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write beat; valid stays up for a following write.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Writes every register, plus one index outside the register file.
    task automatic program_all(input logic [15:0] alpha, input logic [15:0] g_lin,
                               input logic [15:0] g_quad, input logic [15:0] slew,
                               input logic [15:0] lo, input logic [15:0] hi,
                               input logic [15:0] brake, input logic [15:0] floor_val);
        cfg_write(REG_EMA_ALPHA, alpha);
        cfg_write(REG_GAIN_LIN, g_lin);
        cfg_write(REG_GAIN_QUAD, g_quad);
        cfg_write(REG_SLEW_MAX, slew);
        cfg_write(REG_STEER_LO, lo);
        cfg_write(REG_STEER_HI, hi);
        cfg_write(REG_BRAKE_GAIN, brake);
        cfg_write(REG_SCALE_FLOOR, floor_val);
        cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), 16'($urandom));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver ready follows a pattern of modes with random durations.
    int rx_mode = 0;
    int rx_left = 0;
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(4, 40);
        end
        rx_left--;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= 1'b0;
            default: m_axis_tready <= rx_left[0];
        endcase
    end

    // Bus monitor: scores result beats, predicts on frame beats, shadows writes.
    always @(posedge i_clk) begin : bus_monitor
        t_frame       seen;
        t_steer_drive want, got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.marker = m_axis_tdata[1:0];
                got.steer  = m_axis_tdata[17:2];
                got.drive  = m_axis_tdata[33:18];
                if (expected_results.size() == 0) begin
                    $error("result beat with no frame outstanding: %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.marker !== want.marker) begin
                        $error("marker_event: expected %0d, got %0d", want.marker, got.marker);
                        mismatches++;
                    end
                    if (got.steer !== want.steer) begin
                        $error("steer_command: expected %0d, got %0d", want.steer, got.steer);
                        mismatches++;
                    end
                    if (got.drive !== want.drive) begin
                        $error("drive_millivolts: expected %0d, got %0d",
                               $signed(want.drive), $signed(got.drive));
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.bits    = s_axis_tdata[7:0];
                seen.lit     = s_axis_tdata[11:8];
                seen.angle   = s_axis_tdata[25:12];
                seen.present = s_axis_tuser;
                want = predict_steer_drive(seen);
                expected_results.push_back(row_typed ? row_result : want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_EMA_ALPHA:   cfg_shadow.ema_alpha         = i_cfg_data;
                    REG_GAIN_LIN:    cfg_shadow.gain_linear       = i_cfg_data;
                    REG_GAIN_QUAD:   cfg_shadow.gain_quadratic    = i_cfg_data;
                    REG_SLEW_MAX:    cfg_shadow.slew_step_max     = i_cfg_data;
                    REG_STEER_LO:    cfg_shadow.steer_lower_limit = i_cfg_data;
                    REG_STEER_HI:    cfg_shadow.steer_upper_limit = i_cfg_data;
                    REG_BRAKE_GAIN:  cfg_shadow.brake_gain        = i_cfg_data;
                    REG_SCALE_FLOOR: cfg_shadow.drive_scale_floor = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            // Watchdog on cycles without any beat.
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
            end
            if (quiet_count >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", quiet_count);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        t_frame f;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table under the reset configuration.
        for (int k = 0; k < N_DIRECTED; k++) begin
            send_frame(directed_rows[k].f, directed_rows[k].typed, directed_rows[k].r);
        end
        send_random(20);
        drain();
        send_random(20);

        // A long delivery run from a clean state carries the streak past saturation.
        f = random_frame(KIND_NOISE);
        f.present = 1'b0;
        send_frame(f, 1'b0, NOT_TYPED);
        repeat (260) begin
            f = random_frame(KIND_DELIVERY);
            f.angle = 14'($urandom_range(0, 800) - 400);
            send_frame(f, 1'b0, NOT_TYPED);
        end
        drain();

        // Upper extremes.
        program_all(16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'd6144);
        send_random(25);
        drain();

        // Lower extremes with crossed steering limits.
        program_all(16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        send_random(20);
        drain();

        // Floor above the cap, other registers random.
        program_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom_range(0, 32768)), 16'($urandom_range(32768, 65535)),
                    16'($urandom), 16'hFFFF);
        send_random(25);
        drain();

        // Fully random setting.
        program_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 6144)));
        send_random(25);
        drain();

        if (expected_results.size() != 0) begin
            $error("frames with no result beat: %0d", expected_results.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lfsd_pkg.sv
hw/rtl/lfsd_cfg.sv
hw/rtl/lfsd_mul.sv
hw/rtl/lfsd_marker.sv
hw/rtl/line_follow_steer_drive_controller.sv
dv/tb_line_follow_steer_drive_controller.sv
